// ===== rtl/scd_pkg.sv =====
// Shared types and constants of the sprite chain decoder.
`timescale 1ns / 1ps

package scd_pkg;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;

    localparam logic [8:0] X_WRAP_LIMIT = 9'd496;
    localparam logic [8:0] Y_ORIGIN     = 9'd256;
    localparam logic [9:0] SEG_HEIGHT   = 10'd16;

    // Attribute byte bit positions.
    localparam int ATTR_EN    = 0;
    localparam int ATTR_Y8    = 1;
    localparam int ATTR_X8    = 2;
    localparam int ATTR_FLIPY = 3;
    localparam int ATTR_FLIPX = 4;

    // One decoded sprite, ready for segment expansion.
    typedef struct packed {
        logic [15:0] base_tile;
        logic [3:0]  bank;
        logic        mirror_x;
        logic        mirror_y;
        logic [9:0]  x_pos;
        logic [9:0]  y_base;
        logic [2:0]  segs_m1;
    } sprite_cmd_t;

    // Handshake between the queue and a neighbor.
    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

// ===== rtl/scd_front.sv =====
// Front end: accepts attribute entries, drops disabled ones and decodes positions.
`timescale 1ns / 1ps

module scd_front
    import scd_pkg::*;
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    output hs_t                  push_hs,
    output sprite_cmd_t          push_cmd,
    input  logic                 queue_full
);

    logic [7:0]  y_low;
    logic [7:0]  attr_byte;
    logic [7:0]  tile_low;
    logic [7:0]  tile_high;
    logic [3:0]  colour_bank;
    logic [7:0]  x_low;
    logic [8:0]  x9;
    logic [8:0]  y9;
    logic [8:0]  y_top;
    logic        accepted;

    assign y_low       = s_tdata[7:0];
    assign attr_byte   = s_tdata[15:8];
    assign tile_low    = s_tdata[23:16];
    assign tile_high   = s_tdata[31:24];
    assign colour_bank = s_tdata[35:32];
    assign x_low       = s_tdata[43:36];

    assign s_tready = !queue_full;
    assign accepted = s_tvalid && s_tready;

    assign x9    = {attr_byte[ATTR_X8], x_low};
    assign y9    = {attr_byte[ATTR_Y8], y_low};
    assign y_top = Y_ORIGIN - y9;

    always_comb
    begin
        push_cmd.base_tile = {tile_high, tile_low};
        push_cmd.bank      = colour_bank;
        push_cmd.mirror_x  = attr_byte[ATTR_FLIPX];
        push_cmd.mirror_y  = attr_byte[ATTR_FLIPY];
        // Positions past the right edge wrap to the left as negative values.
        push_cmd.x_pos     = {(x9 > X_WRAP_LIMIT), x9};
        push_cmd.y_base    = {1'b0, y_top} - SEG_HEIGHT;
        push_cmd.segs_m1   = attr_byte[7:5];
    end

    // A disabled entry is taken off the bus and never queued.
    assign push_hs.valid = accepted && attr_byte[ATTR_EN];
    assign push_hs.ready = s_tready;

endmodule

// ===== rtl/scd_queue.sv =====
// Short queue of decoded sprites between the front and back ends.
`timescale 1ns / 1ps

module scd_queue
    import scd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  sprite_cmd_t push_cmd,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output sprite_cmd_t pop_cmd
);

    sprite_cmd_t        slot_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count exceeds its depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == QCNT_W'(QDEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

// ===== rtl/scd_back.sv =====
// Back end: expands one decoded sprite into its column of segment words.
`timescale 1ns / 1ps

module scd_back
    import scd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  queue_empty,
    input  sprite_cmd_t           queue_cmd,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    sprite_cmd_t            cmd_reg;
    sprite_cmd_t            cmd_next;
    logic                   busy_reg;
    logic                   busy_next;
    logic [2:0]             k_reg;
    logic [2:0]             k_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic [OUT_DATA_W-1:0]  out_data_next;
    logic                   out_last_reg;
    logic                   out_last_next;
    logic                   load_out;
    logic                   last_seg;
    logic [2:0]             step;
    logic [15:0]            tile_code;
    logic [9:0]             y_pos;

    assign load_out = busy_reg && (!out_valid_reg || m_tready);
    assign last_seg = (k_reg == cmd_reg.segs_m1);
    assign pop      = !queue_empty && (!busy_reg || (load_out && last_seg));

    // With vertical mirroring the first segment gets the smallest y_pos of the column.
    assign step      = cmd_reg.mirror_y ? cmd_reg.segs_m1 - k_reg : k_reg;
    assign tile_code = cmd_reg.base_tile + {13'd0, k_reg};
    assign y_pos     = cmd_reg.y_base - {3'd0, step, 4'd0};

    always_comb
    begin
        cmd_next       = cmd_reg;
        busy_next      = busy_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {6'd0, y_pos, cmd_reg.x_pos, cmd_reg.mirror_y,
                              cmd_reg.mirror_x, cmd_reg.bank, tile_code};
            out_last_next  = last_seg;
            k_next         = k_reg + 1'b1;
            if (last_seg)
            begin
                busy_next = 1'b0;
            end
        end

        if (pop)
        begin
            cmd_next  = queue_cmd;
            busy_next = 1'b1;
            k_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (k_reg <= cmd_reg.segs_m1))
        else $error("segment index ran past the chain length");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!busy_reg || (load_out && last_seg)))
        else $error("new sprite taken while one is still being expanded");

    assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && !last_seg) |=> (busy_reg && k_reg == $past(k_reg) + 3'd1))
        else $error("segment index did not advance");

    assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && last_seg && !pop) |=> !busy_reg)
        else $error("expansion did not finish after the last segment");

endmodule

// ===== rtl/sprite_chain_decoder.sv =====
// Top level of the sprite chain decoder.
`timescale 1ns / 1ps

// Each sprite attribute word is decoded combinationally by the front end and
// queued; a disabled entry is consumed without any output. The back end
// sends one segment word per cycle while the output is not stalled, and an
// enabled entry with a chain field of n gives n+1 segment words, up to eight
// per entry. A two-entry queue lets the input keep accepting while the
// output is stalled, and the output register holds a finished word until
// it is taken. There is no configuration and nothing to clear after reset.
module sprite_chain_decoder
    import scd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // y_low[7:0], attr_byte[15:8], tile_low[23:16], tile_high[31:24],
    // colour_bank[35:32], x_low[43:36], zero[47:44]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tile_code[15:0], palette_bank[19:16], mirror_x[20], mirror_y[21],
    // x_pos[31:22], y_pos[41:32], zero[47:42]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    hs_t         push_hs;
    sprite_cmd_t push_cmd;
    sprite_cmd_t pop_cmd;
    logic        queue_full;
    logic        queue_empty;
    logic        pop;

    scd_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_hs    (push_hs),
        .push_cmd   (push_cmd),
        .queue_full (queue_full)
    );

    scd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_hs.valid && push_hs.ready),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .empty    (queue_empty),
        .pop      (pop),
        .pop_cmd  (pop_cmd)
    );

    scd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_cmd   (pop_cmd),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule
